// ===== rtl/esc_pkg.sv =====
// esc_pkg: shared constants and types of the event sequence checker.
// Request codes, count status codes, register indexes and widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package esc_pkg;

  // Default sizes
  localparam int MAX_FLOW_DEF   = 32;
  localparam int ID_BITS_DEF    = 3;
  localparam int COUNT_BITS_DEF = 16;

  // Fixed field widths
  localparam int REQ_W        = 2;
  localparam int FILTER_W     = 8;
  localparam int EXP_COUNT_W  = 6;
  localparam int ORDER_LOW_W  = 63;
  localparam int ORDER_HIGH_W = 33;
  localparam int IDX_W        = 6;
  localparam int STATUS_W     = 2;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 63;
  // Effective length holds up to 63 (largest expected count)
  localparam int LEN_W        = 7;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PROBE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REPORT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ARM    = 2'd2;

  // Count status codes
  localparam logic [STATUS_W-1:0] CNT_EQUAL = 2'd0;
  localparam logic [STATUS_W-1:0] CNT_FEWER = 2'd1;
  localparam logic [STATUS_W-1:0] CNT_MORE  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_MASK    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_COUNT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ORDER_LOW      = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ORDER_HIGH     = 2'd3;

  // Configuration status seen by the tracker
  typedef struct packed {
    logic             config_valid;
    logic [LEN_W-1:0] len;
  } cfg_stat_t;

endpackage

`default_nettype wire

// ===== rtl/esc_cfg.sv =====
// esc_cfg: configuration registers, expected id table and length clamp.
// Also checks every expected id inside the length against the filter mask.
// Depends on esc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module esc_cfg #(
  parameter int MAX_FLOW = esc_pkg::MAX_FLOW_DEF,
  parameter int ID_BITS  = esc_pkg::ID_BITS_DEF,
  parameter int POS_BITS = (MAX_FLOW > 1) ? $clog2(MAX_FLOW) : 1
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [esc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [esc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic [POS_BITS-1:0]            pos,
  input  wire logic [ID_BITS-1:0]             probe_id,
  output esc_pkg::cfg_stat_t                  stat,
  output logic [ID_BITS-1:0]                  exp_id,
  output logic                                probe_en
);
  import esc_pkg::*;

  localparam int LOW_SLOTS  = ORDER_LOW_W / ID_BITS;
  localparam int TAB_DEPTH  = 1 << POS_BITS;
  localparam int HI_EXT_W   = ORDER_HIGH_W + MAX_FLOW * ID_BITS;
  localparam int ID_SPAN    = 1 << ID_BITS;
  localparam int MASK_EXT_W = (ID_SPAN > FILTER_W) ? ID_SPAN : FILTER_W;

  logic [FILTER_W-1:0]     filter_mask_r;
  logic [EXP_COUNT_W-1:0]  exp_count_r;
  logic [ORDER_LOW_W-1:0]  order_low_r;
  logic [ORDER_HIGH_W-1:0] order_high_r;

  logic [HI_EXT_W-1:0]     hi_ext;
  logic [MASK_EXT_W-1:0]   mask_ext;
  logic [ID_BITS-1:0]      exp_tab [TAB_DEPTH];
  logic [LEN_W-1:0]        len;
  logic                    all_enabled;

  // Register writes; the user must write all four only while idle (not enforced)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_mask_r <= '0;
      exp_count_r   <= '0;
      order_low_r   <= '0;
      order_high_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FILTER_MASK:    filter_mask_r <= cfg_wdata[FILTER_W-1:0];
        CFG_EXPECTED_COUNT: exp_count_r   <= cfg_wdata[EXP_COUNT_W-1:0];
        CFG_ORDER_LOW:      order_low_r   <= cfg_wdata[ORDER_LOW_W-1:0];
        CFG_ORDER_HIGH:     order_high_r  <= cfg_wdata[ORDER_HIGH_W-1:0];
        default: ;
      endcase
    end
  end

  assign hi_ext   = {{(MAX_FLOW * ID_BITS){1'b0}}, order_high_r};
  assign mask_ext = MASK_EXT_W'(filter_mask_r);

  // Unpack expected ids; high word slots past its top read as zero
  for (genvar g = 0; g < TAB_DEPTH; g++) begin : g_tab
    if (g >= MAX_FLOW) begin : g_pad
      assign exp_tab[g] = '0;
    end else if (g < LOW_SLOTS) begin : g_low
      assign exp_tab[g] = order_low_r[g*ID_BITS +: ID_BITS];
    end else begin : g_high
      assign exp_tab[g] = hi_ext[(g-LOW_SLOTS)*ID_BITS +: ID_BITS];
    end
  end

  // Effective length: expected count clamped to the table size
  assign len = ({1'b0, exp_count_r} > LEN_W'(MAX_FLOW)) ? LEN_W'(MAX_FLOW)
                                                         : LEN_W'(exp_count_r);

  // Every expected id inside the length must pass the filter
  always_comb begin
    all_enabled = 1'b1;
    for (int g = 0; g < MAX_FLOW; g++) begin
      if ((LEN_W'(g) < len) && !mask_ext[exp_tab[g]]) begin
        all_enabled = 1'b0;
      end
    end
  end

  assign stat.config_valid = all_enabled;
  assign stat.len          = len;
  assign exp_id            = exp_tab[pos];
  assign probe_en          = mask_ext[probe_id];

endmodule

`default_nettype wire

// ===== rtl/esc_track.sv =====
// esc_track: recording state (armed flag, event count, first mismatch,
// first extra id) and the result fields computed from the updated state.
// Depends on esc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module esc_track #(
  parameter int MAX_FLOW   = esc_pkg::MAX_FLOW_DEF,
  parameter int ID_BITS    = esc_pkg::ID_BITS_DEF,
  parameter int COUNT_BITS = esc_pkg::COUNT_BITS_DEF,
  parameter int POS_BITS   = (MAX_FLOW > 1) ? $clog2(MAX_FLOW) : 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         accept,
  input  wire logic [esc_pkg::REQ_W-1:0]    req_type,
  input  wire logic [ID_BITS-1:0]           event_id,
  input  wire esc_pkg::cfg_stat_t           stat,
  input  wire logic [ID_BITS-1:0]           exp_id,
  input  wire logic                         probe_en,
  output logic [POS_BITS-1:0]               pos,
  output logic                              event_recorded,
  output logic                              config_valid,
  output logic                              verdict_ok,
  output logic [COUNT_BITS-1:0]             call_count,
  output logic [esc_pkg::STATUS_W-1:0]      count_status,
  output logic                              mismatch,
  output logic [esc_pkg::IDX_W-1:0]         mismatch_index,
  output logic [ID_BITS-1:0]                expected_id,
  output logic [ID_BITS-1:0]                found_id,
  output logic [ID_BITS-1:0]                extra_id
);
  import esc_pkg::*;

  localparam int CMP_W = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;

  logic                  armed_r, armed_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  mm_r, mm_nxt;
  logic [IDX_W-1:0]      bad_idx_r, bad_idx_nxt;
  logic [ID_BITS-1:0]    bad_exp_r, bad_exp_nxt;
  logic [ID_BITS-1:0]    bad_found_r, bad_found_nxt;
  logic [ID_BITS-1:0]    ovf_id_r, ovf_id_nxt;
  logic                  recorded;

  logic [CMP_W-1:0]      cnt_cur, cnt_new, len_ext;

  assign len_ext = CMP_W'(stat.len);
  assign cnt_cur = CMP_W'(count_r);
  assign pos     = count_r[POS_BITS-1:0];

  // Next state for the item at the input
  always_comb begin
    armed_nxt     = armed_r;
    count_nxt     = count_r;
    mm_nxt        = mm_r;
    bad_idx_nxt   = bad_idx_r;
    bad_exp_nxt   = bad_exp_r;
    bad_found_nxt = bad_found_r;
    ovf_id_nxt    = ovf_id_r;
    recorded      = 1'b0;
    case (req_type)
      REQ_PROBE: begin
        if (armed_r && probe_en) begin
          if (cnt_cur < len_ext) begin
            // compare against the expected id at this position
            if ((exp_id != event_id) && !mm_r) begin
              mm_nxt        = 1'b1;
              bad_idx_nxt   = count_r[IDX_W-1:0] + IDX_W'(1);
              bad_exp_nxt   = exp_id;
              bad_found_nxt = event_id;
            end
          end else if (cnt_cur == len_ext) begin
            ovf_id_nxt = event_id;
          end
          // saturating count
          if (!(&count_r)) begin
            count_nxt = count_r + COUNT_BITS'(1);
          end
          recorded = 1'b1;
        end
      end
      REQ_REPORT: begin
        armed_nxt = 1'b0;
      end
      REQ_ARM: begin
        armed_nxt     = 1'b1;
        count_nxt     = '0;
        mm_nxt        = 1'b0;
        bad_idx_nxt   = '0;
        bad_exp_nxt   = '0;
        bad_found_nxt = '0;
        ovf_id_nxt    = '0;
      end
      default: ;
    endcase
  end

  // State update on accepted items only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r     <= 1'b0;
      count_r     <= '0;
      mm_r        <= 1'b0;
      bad_idx_r   <= '0;
      bad_exp_r   <= '0;
      bad_found_r <= '0;
      ovf_id_r    <= '0;
    end else if (accept) begin
      armed_r     <= armed_nxt;
      count_r     <= count_nxt;
      mm_r        <= mm_nxt;
      bad_idx_r   <= bad_idx_nxt;
      bad_exp_r   <= bad_exp_nxt;
      bad_found_r <= bad_found_nxt;
      ovf_id_r    <= ovf_id_nxt;
    end
  end

  // Result fields reflect the state after this item
  assign cnt_new = CMP_W'(count_nxt);

  always_comb begin
    if (cnt_new < len_ext) begin
      count_status = CNT_FEWER;
    end else if (cnt_new > len_ext) begin
      count_status = CNT_MORE;
    end else begin
      count_status = CNT_EQUAL;
    end
  end

  assign event_recorded = recorded;
  assign config_valid   = stat.config_valid;
  assign verdict_ok     = !mm_nxt && (count_status == CNT_EQUAL);
  assign call_count     = count_nxt;
  assign mismatch       = mm_nxt;
  assign mismatch_index = mm_nxt ? bad_idx_nxt : '0;
  assign expected_id    = mm_nxt ? bad_exp_nxt : '0;
  assign found_id       = mm_nxt ? bad_found_nxt : '0;
  assign extra_id       = (count_status == CNT_MORE) ? ovf_id_nxt : '0;

endmodule

`default_nettype wire

// ===== rtl/event_sequence_checker.sv =====
// Event sequence checker: probe events from a trace bus are checked on the
// fly against an expected id sequence held in configuration registers.
//
// Channels: in_valid/in_stall carry one item (request type, event id);
// out_valid/out_stall carry one result item per input item. cfg_we with
// cfg_index and cfg_wdata writes a configuration register; the user must do
// so only while idle, which the block does not enforce. A probe item is
// counted when the block is armed and its id passes the filter mask. A report
// item stops recording; an arm item clears the verdict state and starts
// recording. Every item returns the current verdict.
// Result: registered, valid in the cycle after the item is accepted.
// Throughput: one item per cycle unless stalled; the count, the expected-id
// mux and the compare sit between the state registers and result register.
// Stall: the result register holds while out_stall is high, and in_stall is
// raised only while a result waits in it, so the block takes a new item in
// the same cycle the old result leaves.
// Reset: synchronous, active low; clears configuration, disarms the block
// and empties the result register.
// Depends on esc_pkg, esc_cfg, esc_track.
`timescale 1ns / 1ps
`default_nettype none

module event_sequence_checker #(
  parameter int MAX_FLOW   = esc_pkg::MAX_FLOW_DEF,
  parameter int ID_BITS    = esc_pkg::ID_BITS_DEF,
  parameter int COUNT_BITS = esc_pkg::COUNT_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration write port
  input  wire logic                            cfg_we,
  input  wire logic [esc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [esc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // input channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [esc_pkg::REQ_W-1:0]       in_req_type,
  input  wire logic [ID_BITS-1:0]              in_event_id,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_event_recorded,
  output logic                                 out_config_valid,
  output logic                                 out_verdict_ok,
  output logic [COUNT_BITS-1:0]                out_call_count,
  output logic [esc_pkg::STATUS_W-1:0]         out_count_status,
  output logic                                 out_mismatch,
  output logic [esc_pkg::IDX_W-1:0]            out_mismatch_index,
  output logic [ID_BITS-1:0]                   out_expected_id,
  output logic [ID_BITS-1:0]                   out_found_id,
  output logic [ID_BITS-1:0]                   out_extra_id
);
  import esc_pkg::*;

  localparam int POS_BITS = (MAX_FLOW > 1) ? $clog2(MAX_FLOW) : 1;

  cfg_stat_t             stat;
  logic [ID_BITS-1:0]    exp_id;
  logic                  probe_en;
  logic [POS_BITS-1:0]   pos;
  logic                  in_accept;

  logic                  res_recorded;
  logic                  res_config_valid;
  logic                  res_verdict_ok;
  logic [COUNT_BITS-1:0] res_call_count;
  logic [STATUS_W-1:0]   res_count_status;
  logic                  res_mismatch;
  logic [IDX_W-1:0]      res_mismatch_index;
  logic [ID_BITS-1:0]    res_expected_id;
  logic [ID_BITS-1:0]    res_found_id;
  logic [ID_BITS-1:0]    res_extra_id;

  logic                  out_valid_r;
  logic                  recorded_r;
  logic                  config_valid_r;
  logic                  verdict_ok_r;
  logic [COUNT_BITS-1:0] call_count_r;
  logic [STATUS_W-1:0]   count_status_r;
  logic                  mismatch_r;
  logic [IDX_W-1:0]      mismatch_index_r;
  logic [ID_BITS-1:0]    expected_id_r;
  logic [ID_BITS-1:0]    found_id_r;
  logic [ID_BITS-1:0]    extra_id_r;

  // Handshake: take an item unless a result is held back
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  esc_cfg #(
    .MAX_FLOW (MAX_FLOW),
    .ID_BITS  (ID_BITS),
    .POS_BITS (POS_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pos       (pos),
    .probe_id  (in_event_id),
    .stat      (stat),
    .exp_id    (exp_id),
    .probe_en  (probe_en)
  );

  esc_track #(
    .MAX_FLOW   (MAX_FLOW),
    .ID_BITS    (ID_BITS),
    .COUNT_BITS (COUNT_BITS),
    .POS_BITS   (POS_BITS)
  ) u_track (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (in_accept),
    .req_type       (in_req_type),
    .event_id       (in_event_id),
    .stat           (stat),
    .exp_id         (exp_id),
    .probe_en       (probe_en),
    .pos            (pos),
    .event_recorded (res_recorded),
    .config_valid   (res_config_valid),
    .verdict_ok     (res_verdict_ok),
    .call_count     (res_call_count),
    .count_status   (res_count_status),
    .mismatch       (res_mismatch),
    .mismatch_index (res_mismatch_index),
    .expected_id    (res_expected_id),
    .found_id       (res_found_id),
    .extra_id       (res_extra_id)
  );

  // Result register valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload, loaded with each accepted item
  always_ff @(posedge clk) begin
    if (in_accept) begin
      recorded_r       <= res_recorded;
      config_valid_r   <= res_config_valid;
      verdict_ok_r     <= res_verdict_ok;
      call_count_r     <= res_call_count;
      count_status_r   <= res_count_status;
      mismatch_r       <= res_mismatch;
      mismatch_index_r <= res_mismatch_index;
      expected_id_r    <= res_expected_id;
      found_id_r       <= res_found_id;
      extra_id_r       <= res_extra_id;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_recorded = recorded_r;
  assign out_config_valid   = config_valid_r;
  assign out_verdict_ok     = verdict_ok_r;
  assign out_call_count     = call_count_r;
  assign out_count_status   = count_status_r;
  assign out_mismatch       = mismatch_r;
  assign out_mismatch_index = mismatch_index_r;
  assign out_expected_id    = expected_id_r;
  assign out_found_id       = found_id_r;
  assign out_extra_id       = extra_id_r;

  // An accepted item always shows up as a result next cycle
  a_accept_gives_result: assert property (
    @(posedge clk) disable iff (!rst_n) in_accept |=> out_valid
  ) else $error("accepted item produced no result");

  // A good verdict needs no mismatch and an equal count
  a_verdict_consistent: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && out_verdict_ok) |-> (!out_mismatch && (out_count_status == CNT_EQUAL))
  ) else $error("verdict_ok with mismatch or unequal count");

  // Mismatch details stay zero while no mismatch is latched
  a_mismatch_fields: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && !out_mismatch) |->
      ((out_mismatch_index == '0) && (out_expected_id == '0) && (out_found_id == '0))
  ) else $error("mismatch fields set without a mismatch");

  // Extra id only reported when the count ran past the length
  a_extra_only_when_more: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && (out_count_status != CNT_MORE)) |-> (out_extra_id == '0)
  ) else $error("extra id reported without an overrun");

endmodule

`default_nettype wire

// ===== tb/sv/tb_event_sequence_checker.sv =====
// Testbench for event_sequence_checker: drives arm/probe/report items and
// checks each result item against a verdict predictor held in a scoreboard class.
// Depends on esc_pkg and the event_sequence_checker RTL.
`timescale 1ns / 1ps

module tb_event_sequence_checker;
  import esc_pkg::*;

  localparam int IDW       = ID_BITS_DEF;
  localparam int CNTW      = COUNT_BITS_DEF;
  localparam int MAXF      = MAX_FLOW_DEF;
  localparam int LOW_SLOTS = 63 / IDW;
  localparam int QUIET_MAX = 2000;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  // One result item, field by field
  typedef struct packed {
    logic                recorded;
    logic                cfg_ok;
    logic                verdict_ok;
    logic [CNTW-1:0]     calls;
    logic [STATUS_W-1:0] status;
    logic                mismatch;
    logic [IDX_W-1:0]    bad_index;
    logic [IDW-1:0]      exp_id;
    logic [IDW-1:0]      found_id;
    logic [IDW-1:0]      extra_id;
  } verdict_t;

  // Verdict predictor and queue of expected result items
  class verdict_board;
    logic [FILTER_W-1:0]     mask;
    logic [EXP_COUNT_W-1:0]  exp_count;
    logic [ORDER_LOW_W-1:0]  order_lo;
    logic [ORDER_HIGH_W-1:0] order_hi;
    logic                    armed;
    logic [CNTW-1:0]         tally;
    logic                    mis_seen;
    logic [IDX_W-1:0]        bad_pos;
    logic [IDW-1:0]          bad_exp;
    logic [IDW-1:0]          bad_found;
    logic [IDW-1:0]          over_id;
    verdict_t                pending[$];
    int                      errors;

    function new();
      mask      = '0;
      exp_count = '0;
      order_lo  = '0;
      order_hi  = '0;
      armed     = 1'b0;
      errors    = 0;
      clear_run();
    endfunction

    function void clear_run();
      tally     = '0;
      mis_seen  = 1'b0;
      bad_pos   = '0;
      bad_exp   = '0;
      bad_found = '0;
      over_id   = '0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_FILTER_MASK:    mask      = data[FILTER_W-1:0];
        CFG_EXPECTED_COUNT: exp_count = data[EXP_COUNT_W-1:0];
        CFG_ORDER_LOW:      order_lo  = data[ORDER_LOW_W-1:0];
        CFG_ORDER_HIGH:     order_hi  = data[ORDER_HIGH_W-1:0];
        default: ;
      endcase
    endfunction

    // Lengths above the largest sequence are clamped
    function int eff_len();
      return (int'(exp_count) > MAXF) ? MAXF : int'(exp_count);
    endfunction

    function logic [IDW-1:0] expected_at(int pos);
      if (pos < LOW_SLOTS)
        return IDW'(order_lo >> (IDW * pos));
      return IDW'(order_hi >> (IDW * (pos - LOW_SLOTS)));
    endfunction

    function logic id_on(logic [IDW-1:0] id);
      return mask[id];
    endfunction

    // Ids that the expected sequence needs to pass the filter
    function logic [FILTER_W-1:0] needed_mask();
      logic [FILTER_W-1:0] need;
      need = '0;
      for (int p = 0; p < eff_len(); p++) need[expected_at(p)] = 1'b1;
      return need;
    endfunction

    function void note_input(logic [REQ_W-1:0] req, logic [IDW-1:0] id);
      verdict_t v;
      int       len;
      v   = '0;
      len = eff_len();
      if (req == REQ_PROBE) begin
        if (armed && id_on(id)) begin
          if (int'(tally) < len) begin
            if (expected_at(int'(tally)) != id && !mis_seen) begin
              mis_seen  = 1'b1;
              bad_pos   = IDX_W'(int'(tally) + 1);
              bad_exp   = expected_at(int'(tally));
              bad_found = id;
            end
          end else if (int'(tally) == len) begin
            over_id = id;
          end
          if (tally != {CNTW{1'b1}}) tally = tally + 1'b1;
          v.recorded = 1'b1;
        end
      end else if (req == REQ_REPORT) begin
        armed = 1'b0;
      end else if (req == REQ_ARM) begin
        clear_run();
        armed = 1'b1;
      end
      // request code 3 leaves everything alone
      if (int'(tally) < len)      v.status = CNT_FEWER;
      else if (int'(tally) > len) v.status = CNT_MORE;
      else                        v.status = CNT_EQUAL;
      v.cfg_ok     = ((needed_mask() & ~mask) == '0);
      v.verdict_ok = !mis_seen && (v.status == CNT_EQUAL);
      v.calls      = tally;
      v.mismatch   = mis_seen;
      v.bad_index  = mis_seen ? bad_pos : '0;
      v.exp_id     = mis_seen ? bad_exp : '0;
      v.found_id   = mis_seen ? bad_found : '0;
      v.extra_id   = (v.status == CNT_MORE) ? over_id : '0;
      pending.push_back(v);
    endfunction

    function void cmp(string name, logic [CNTW-1:0] want, logic [CNTW-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(verdict_t got);
      verdict_t want;
      if (pending.size() == 0) begin
        $error("result item with nothing pending");
        errors++;
        return;
      end
      want = pending.pop_front();
      cmp("event_recorded", CNTW'(want.recorded),   CNTW'(got.recorded));
      cmp("config_valid",   CNTW'(want.cfg_ok),     CNTW'(got.cfg_ok));
      cmp("verdict_ok",     CNTW'(want.verdict_ok), CNTW'(got.verdict_ok));
      cmp("call_count",     want.calls,             got.calls);
      cmp("count_status",   CNTW'(want.status),     CNTW'(got.status));
      cmp("mismatch",       CNTW'(want.mismatch),   CNTW'(got.mismatch));
      cmp("mismatch_index", CNTW'(want.bad_index),  CNTW'(got.bad_index));
      cmp("expected_id",    CNTW'(want.exp_id),     CNTW'(got.exp_id));
      cmp("found_id",       CNTW'(want.found_id),   CNTW'(got.found_id));
      cmp("extra_id",       CNTW'(want.extra_id),   CNTW'(got.extra_id));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [REQ_W-1:0]       in_req_type = '0;
  logic [IDW-1:0]         in_event_id = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   out_event_recorded;
  logic                   out_config_valid;
  logic                   out_verdict_ok;
  logic [CNTW-1:0]        out_call_count;
  logic [STATUS_W-1:0]    out_count_status;
  logic                   out_mismatch;
  logic [IDX_W-1:0]       out_mismatch_index;
  logic [IDW-1:0]         out_expected_id;
  logic [IDW-1:0]         out_found_id;
  logic [IDW-1:0]         out_extra_id;

  int           send_idle_pct = 9;
  int           recv_idle_pct = 65;
  int           quiet_cycles = 0;
  verdict_board sb;

  event_sequence_checker dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_event_id       (in_event_id),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_recorded(out_event_recorded),
    .out_config_valid  (out_config_valid),
    .out_verdict_ok    (out_verdict_ok),
    .out_call_count    (out_call_count),
    .out_count_status  (out_count_status),
    .out_mismatch      (out_mismatch),
    .out_mismatch_index(out_mismatch_index),
    .out_expected_id   (out_expected_id),
    .out_found_id      (out_found_id),
    .out_extra_id      (out_extra_id)
  );

  always #6 clk = ~clk;

  // Receiver stalls at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result('{out_event_recorded, out_config_valid, out_verdict_ok,
                        out_call_count, out_count_status, out_mismatch,
                        out_mismatch_index, out_expected_id, out_found_id,
                        out_extra_id});
    end
  end

  // Cycles without any handshake on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_MAX) @(posedge clk);
    $display("event_sequence_checker verification failed");
    $finish;
  end

  function automatic logic [CFG_DATA_W-1:0] rand63();
    return CFG_DATA_W'({$urandom, $urandom});
  endfunction

  // Send one item; valid stays up until the next call or until input_quiet
  task automatic send_item(input logic [REQ_W-1:0] req, input logic [IDW-1:0] id);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid    <= 1'b0;
      in_req_type <= REQ_W'($urandom);
      in_event_id <= IDW'($urandom);
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_event_id <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(req, id);
  endtask

  task automatic input_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Register write; junk above the register width must be dropped
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic program_sequence(input logic [EXP_COUNT_W-1:0] cnt,
                                  input logic [ORDER_LOW_W-1:0] lo,
                                  input logic [ORDER_HIGH_W-1:0] hi);
    logic [CFG_DATA_W-1:0] junk;
    junk = rand63();
    write_reg(CFG_ORDER_LOW, lo);
    write_reg(CFG_ORDER_HIGH, {junk[CFG_DATA_W-1:ORDER_HIGH_W], hi});
    write_reg(CFG_EXPECTED_COUNT, {junk[CFG_DATA_W-1:EXP_COUNT_W], cnt});
  endtask

  task automatic program_mask(input logic [FILTER_W-1:0] mask);
    logic [CFG_DATA_W-1:0] junk;
    junk = rand63();
    write_reg(CFG_FILTER_MASK, {junk[CFG_DATA_W-1:FILTER_W], mask});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Pick a probe id: mostly the one expected at the current position
  function automatic logic [IDW-1:0] pick_probe();
    if ($urandom_range(0, 6) != 0 && int'(sb.tally) < sb.eff_len())
      return sb.expected_at(int'(sb.tally));
    return IDW'($urandom);
  endfunction

  // Mostly arm / probes / report runs, some random noise between them
  task automatic run_traffic(input int n_items);
    int sent;
    int probes;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 4) != 0) begin
        send_item(REQ_ARM, IDW'($urandom));
        probes = sb.eff_len() + $urandom_range(0, 4) - 2;
        if (probes < 0) probes = 0;
        for (int k = 0; k < probes; k++) send_item(REQ_PROBE, pick_probe());
        sent += probes + 1;
        if ($urandom_range(0, 9) != 0) begin
          send_item(REQ_REPORT, IDW'($urandom));
          sent++;
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_item(REQ_W'($urandom), IDW'($urandom));
          sent++;
        end
      end
    end
    input_quiet();
    drain();
  endtask

  task automatic random_config(input int kind);
    logic [EXP_COUNT_W-1:0] cnt;
    logic [FILTER_W-1:0]    mask;
    cnt = ($urandom_range(0, 9) == 0) ? EXP_COUNT_W'($urandom_range(MAXF + 1, 63))
                                       : EXP_COUNT_W'($urandom_range(0, MAXF));
    case (kind)
      0: program_sequence(EXP_COUNT_W'(MAXF), '1, '1);
      1: program_sequence('0, '0, '0);
      2: program_sequence(6'd63, rand63(), ORDER_HIGH_W'(rand63()));
      default: program_sequence(cnt, rand63(), ORDER_HIGH_W'(rand63()));
    endcase
    if (kind == 0)      mask = '1;
    else if (kind == 1) mask = '0;
    else if ($urandom_range(0, 3) == 0) mask = FILTER_W'($urandom);
    else mask = sb.needed_mask() | FILTER_W'($urandom & $urandom);
    program_mask(mask);
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: ids 3,5,7,0 expected, id 6 filtered out
    program_sequence(6'd4, {51'd0, 3'd0, 3'd7, 3'd5, 3'd3}, '0);
    program_mask(8'hBF);
    send_item(REQ_PROBE, 3'd7);       // not armed yet
    send_item(REQ_UNUSED, 3'd5);
    send_item(REQ_ARM, 3'd0);
    send_item(REQ_PROBE, 3'd3);
    send_item(REQ_PROBE, 3'd6);       // filtered out
    send_item(REQ_PROBE, 3'd5);
    send_item(REQ_PROBE, 3'd0);       // first mismatch
    send_item(REQ_PROBE, 3'd1);
    send_item(REQ_PROBE, 3'd4);       // first id past the end
    send_item(REQ_PROBE, 3'd2);
    send_item(REQ_REPORT, 3'd0);
    send_item(REQ_PROBE, 3'd3);       // recording stopped
    send_item(REQ_ARM, 3'd7);
    send_item(REQ_PROBE, 3'd3);
    send_item(REQ_PROBE, 3'd5);
    send_item(REQ_PROBE, 3'd7);
    send_item(REQ_PROBE, 3'd0);
    send_item(REQ_REPORT, 3'd1);
    input_quiet();
    drain();

    // Oversized length, all-ones order, id 7 not enabled
    program_sequence(6'd63, '1, '1);
    program_mask(8'h7F);
    send_item(REQ_ARM, 3'd2);
    send_item(REQ_PROBE, 3'd7);
    send_item(REQ_PROBE, 3'd0);
    send_item(REQ_REPORT, 3'd6);
    input_quiet();
    drain();

    // Empty sequence: every counted probe is extra
    program_sequence('0, '0, '0);
    program_mask(8'hFF);
    send_item(REQ_ARM, 3'd1);
    send_item(REQ_PROBE, 3'd6);
    send_item(REQ_PROBE, 3'd1);
    send_item(REQ_REPORT, 3'd4);
    send_item(REQ_UNUSED, 3'd2);
    input_quiet();
    drain();

    // Random phases under three idling regimes
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        send_idle_pct = 65;
        recv_idle_pct = 9;
      end else if (ph == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_config(ph);
      run_traffic(152);
    end

    repeat (5) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("event_sequence_checker verification clean");
    end else begin
      $display("event_sequence_checker verification failed");
    end
    $finish;
  end

endmodule
